[sv/dijkstra_shortest_paths_assert.svh]
// Assertion macros for the shortest path engine.
`ifndef DIJKSTRA_SHORTEST_PATHS_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATHS_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shortest path engine: assertion failed");

// Check a condition in the cycle after its trigger.
`define DSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shortest path engine: assertion failed");

`endif

[sv/dsp_pkg.sv]
package dsp_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;
    localparam int COST_BITS_DEF    = 16;

    localparam int VTX_W     = 10;
    localparam int COST_W    = 16;
    localparam int DIST_BITS = 31;
    localparam int COUNT_W   = 11;
    localparam int VC_W      = 11;

    localparam logic [DIST_BITS-1:0] UNREACHED = 31'h7FFF_FFFF;
    localparam logic [DIST_BITS-1:0] DIST_CAP  = 31'h7FFF_FFFE;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_SOURCE       = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } status_t;

endpackage

[sv/dsp_if.sv]
interface dsp_req_if;
    logic                      valid;
    logic                      ready;
    dsp_pkg::op_t              operation;
    logic [dsp_pkg::VTX_W-1:0] from_vertex;
    logic [dsp_pkg::VTX_W-1:0] to_vertex;
    logic [dsp_pkg::COST_W-1:0] edge_cost;

    modport source (output valid, operation, from_vertex, to_vertex, edge_cost, input ready);
    modport sink   (input valid, operation, from_vertex, to_vertex, edge_cost, output ready);
endinterface

interface dsp_rsp_if;
    logic                          valid;
    logic                          ready;
    dsp_pkg::status_t              status;
    logic [dsp_pkg::DIST_BITS-1:0] distance;
    logic                          reachable;
    logic [dsp_pkg::COUNT_W-1:0]   reached_count;

    modport source (output valid, status, distance, reachable, reached_count, input ready);
    modport sink   (input valid, status, distance, reachable, reached_count, output ready);
endinterface

[sv/dijkstra_shortest_paths.sv]
// Single-source shortest path engine (Dijkstra with a lazy binary min-heap).
// Requests arrive on req (valid/ready): clear graph, add edge, run search from
// the configured source, or read one vertex distance. Each request yields
// exactly one response on rsp (valid/ready), held in an output register.
// Registers vertex_count and source_vertex sit on the APB port (0x0, 0x4).
// Steps: clear sweeps every distance/head row, one row per cycle; add edge
// reads the head, then writes the edge; read fetches one distance. A run sweeps
// the distance memory, then loops over heap pops: each pop sifts the former
// last entry down, each edge of the popped vertex is relaxed, each improved
// distance is pushed and sifted up, and a final pass counts reached vertices.
// All heap work goes through one heap memory with one read and one write port.
// One request is in flight at a time; req.ready is high only in idle with the
// response register free or being emptied in the same cycle.
// After reset a clearing pass resets distances and
// adjacency heads; no request is taken meanwhile (APB writes are).
// A stalled receiver holds the response; the next request waits for it.
`include "dijkstra_shortest_paths_assert.svh"

module dijkstra_shortest_paths #(
    parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = dsp_pkg::MAX_EDGES_DEF,
    parameter int COST_BITS    = dsp_pkg::COST_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dsp_req_if.sink     req,
    dsp_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DB   = dsp_pkg::DIST_BITS;
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int CW   = (NW > dsp_pkg::VC_W) ? NW : dsp_pkg::VC_W;
    localparam int EW   = $clog2(MAX_EDGES + 1);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int HCAP = MAX_EDGES + 1;
    localparam int HAW  = $clog2(HCAP);
    localparam int HW   = $clog2(HCAP + 1);
    localparam int KW   = DB + VW;

    typedef enum logic [21:0] {
        S_IDLE  = 22'd1 << 0,
        S_SWEEP = 22'd1 << 1,
        S_ADD   = 22'd1 << 2,
        S_RDD   = 22'd1 << 3,
        S_INIT  = 22'd1 << 4,
        S_POP   = 22'd1 << 5,
        S_POPL  = 22'd1 << 6,
        S_SDI   = 22'd1 << 7,
        S_SDC   = 22'd1 << 8,
        S_SDC1  = 22'd1 << 9,
        S_SDCMP = 22'd1 << 10,
        S_SDM   = 22'd1 << 11,
        S_CHK   = 22'd1 << 12,
        S_CHK2  = 22'd1 << 13,
        S_HEAD  = 22'd1 << 14,
        S_ELOOP = 22'd1 << 15,
        S_EDGE  = 22'd1 << 16,
        S_RELAX = 22'd1 << 17,
        S_PUC   = 22'd1 << 18,
        S_PUM   = 22'd1 << 19,
        S_CNT   = 22'd1 << 20,
        S_CNTA  = 22'd1 << 21
    } state_t;

    // ---------------- configuration registers ----------------
    logic [dsp_pkg::VC_W-1:0]  vertex_count_reg;
    logic [dsp_pkg::VTX_W-1:0] source_vertex_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= (dsp_pkg::VC_W)'(1024);
            source_vertex_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == dsp_pkg::REG_VERTEX_COUNT)
                vertex_count_reg <= pwdata[dsp_pkg::VC_W-1:0];
            else
                source_vertex_reg <= pwdata[dsp_pkg::VTX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == dsp_pkg::REG_SOURCE) ? 32'(source_vertex_reg)
                                                      : 32'(vertex_count_reg);

    // Effective vertex count: zero or oversize saturates to the capacity.
    logic [CW-1:0] vc_cw;
    logic [CW-1:0] n_cw;
    assign vc_cw = CW'(vertex_count_reg);
    assign n_cw  = (vc_cw == '0 || vc_cw > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_cw;

    // ---------------- sequencer state ----------------
    state_t               state_reg, state_next;
    logic                 boot_reg, boot_next;
    logic                 sweep_graph_reg, sweep_graph_next;
    logic                 run_bad_reg, run_bad_next;
    logic [VW-1:0]        idx_reg, idx_next;
    logic [EW-1:0]        edge_total_reg, edge_total_next;
    logic [HW-1:0]        heap_fill_reg, heap_fill_next;

    logic [VW-1:0]        req_a_reg, req_a_next;
    logic [VW-1:0]        req_b_reg, req_b_next;
    logic [COST_BITS-1:0] w_reg, w_next;
    logic [HAW-1:0]       hi_reg, hi_next;
    logic [HAW-1:0]       bc_reg, bc_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [KW-1:0]        best_reg, best_next;
    logic [KW-1:0]        top_reg, top_next;
    logic [EW-1:0]        link_reg, link_next;
    logic [DB-1:0]        nd_reg, nd_next;
    logic [VW-1:0]        v_reg, v_next;
    logic [NW-1:0]        cnt_reg, cnt_next;

    // ---------------- memories ----------------
    logic [DB-1:0]        dist_mem [MAX_VERTICES];
    logic                 dist_we;
    logic [VW-1:0]        dist_wa, dist_ra;
    logic [DB-1:0]        dist_wd, dist_rd;

    logic [EW-1:0]        head_mem [MAX_VERTICES];
    logic                 head_we;
    logic [VW-1:0]        head_wa, head_ra;
    logic [EW-1:0]        head_wd, head_rd;

    logic [VW-1:0]        tgt_mem  [MAX_EDGES];
    logic [COST_BITS-1:0] wt_mem   [MAX_EDGES];
    logic [EW-1:0]        nxt_mem  [MAX_EDGES];
    logic                 edge_we;
    logic [EAW-1:0]       edge_wa, edge_ra;
    logic [VW-1:0]        tgt_rd;
    logic [COST_BITS-1:0] wt_rd;
    logic [EW-1:0]        nxt_rd;

    logic [KW-1:0]        heap_mem [HCAP];
    logic                 heap_we;
    logic [HAW-1:0]       heap_wa, heap_ra;
    logic [KW-1:0]        heap_wd, heap_rd;

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        dist_rd <= dist_mem[dist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            tgt_mem[edge_wa] <= VW'(req_b_reg);
            wt_mem[edge_wa]  <= w_reg;
            nxt_mem[edge_wa] <= head_rd;
        end
        tgt_rd <= tgt_mem[edge_ra];
        wt_rd  <= wt_mem[edge_ra];
        nxt_rd <= nxt_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_wa] <= heap_wd;
        heap_rd <= heap_mem[heap_ra];
    end

    logic                 res_valid_reg, res_valid_next;
    dsp_pkg::status_t     res_status_reg;
    logic [DB-1:0]        res_dist_reg;
    logic                 res_reach_reg;
    logic [dsp_pkg::COUNT_W-1:0] res_count_reg;

    logic                 fin;
    dsp_pkg::status_t     fin_status;
    logic [DB-1:0]        fin_dist;
    logic                 fin_reach;
    logic [NW-1:0]        fin_count;

    // shared datapath helpers
    logic [HAW+1:0]       c_w, c1_w, fill_c;
    logic [HAW-1:0]       p_w;
    logic [DB:0]          sum_w;
    logic [DB-1:0]        sat_w;
    logic [VW-1:0]        top_v;
    logic [DB-1:0]        top_d;
    logic                 accept;

    assign c_w    = (HAW+2)'({hi_reg, 1'b1});
    assign c1_w   = c_w + (HAW+2)'(1);
    assign fill_c = (HAW+2)'(heap_fill_reg);
    assign p_w    = HAW'((hi_reg - HAW'(1)) >> 1);
    assign top_v  = top_reg[VW-1:0];
    assign top_d  = top_reg[KW-1:VW];
    assign sum_w  = {1'b0, top_d} + (DB+1)'(wt_rd);
    assign sat_w  = (sum_w > (DB+1)'(dsp_pkg::DIST_CAP)) ? dsp_pkg::DIST_CAP : sum_w[DB-1:0];

    assign req.ready = (state_reg == S_IDLE) && (!res_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next       = state_reg;
        boot_next        = boot_reg;
        sweep_graph_next = sweep_graph_reg;
        run_bad_next     = run_bad_reg;
        idx_next         = idx_reg;
        edge_total_next  = edge_total_reg;
        heap_fill_next   = heap_fill_reg;
        req_a_next       = req_a_reg;
        req_b_next       = req_b_reg;
        w_next           = w_reg;
        hi_next          = hi_reg;
        bc_next          = bc_reg;
        key_next         = key_reg;
        best_next        = best_reg;
        top_next         = top_reg;
        link_next        = link_reg;
        nd_next          = nd_reg;
        v_next           = v_reg;
        cnt_next         = cnt_reg;

        fin        = 1'b0;
        fin_status = dsp_pkg::STS_OK;
        fin_dist   = '0;
        fin_reach  = 1'b0;
        fin_count  = '0;

        dist_we = 1'b0;  dist_wa = idx_reg;  dist_wd = dsp_pkg::UNREACHED;  dist_ra = idx_reg;
        head_we = 1'b0;  head_wa = idx_reg;  head_wd = EW'(MAX_EDGES);    head_ra = req_a_reg;
        edge_we = 1'b0;  edge_wa = EAW'(edge_total_reg);                   edge_ra = EAW'(link_reg);
        heap_we = 1'b0;  heap_wa = hi_reg;   heap_wd = key_reg;            heap_ra = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                head_ra = VW'(req.from_vertex);
                dist_ra = VW'(req.from_vertex);
                if (accept)
                begin
                    req_a_next = VW'(req.from_vertex);
                    req_b_next = VW'(req.to_vertex);
                    w_next     = COST_BITS'(req.edge_cost);
                    unique case (req.operation)
                        dsp_pkg::OP_CLEAR:
                        begin
                            sweep_graph_next = 1'b1;
                            run_bad_next     = 1'b0;
                            idx_next         = '0;
                            state_next       = S_SWEEP;
                        end
                        dsp_pkg::OP_ADD:
                        begin
                            if (CW'(req.from_vertex) >= n_cw || CW'(req.to_vertex) >= n_cw)
                            begin
                                fin        = 1'b1;
                                fin_status = dsp_pkg::STS_RANGE;
                            end
                            else if (edge_total_reg == EW'(MAX_EDGES))
                            begin
                                fin        = 1'b1;
                                fin_status = dsp_pkg::STS_FULL;
                            end
                            else
                                state_next = S_ADD;
                        end
                        dsp_pkg::OP_RUN:
                        begin
                            sweep_graph_next = 1'b0;
                            run_bad_next     = (CW'(source_vertex_reg) >= n_cw);
                            idx_next         = '0;
                            state_next       = S_SWEEP;
                        end
                        dsp_pkg::OP_READ:
                        begin
                            if (CW'(req.from_vertex) >= n_cw)
                            begin
                                fin        = 1'b1;
                                fin_status = dsp_pkg::STS_RANGE;
                                fin_dist   = dsp_pkg::UNREACHED;
                            end
                            else
                                state_next = S_RDD;
                        end
                    endcase
                end
            end

            // One row per cycle: distances back to unreached, heads to null on clear.
            S_SWEEP:
            begin
                dist_we = 1'b1;
                head_we = sweep_graph_reg;
                idx_next = idx_reg + VW'(1);
                if (idx_reg == VW'(MAX_VERTICES - 1))
                begin
                    if (sweep_graph_reg)
                        edge_total_next = '0;
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (sweep_graph_reg)
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (run_bad_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = dsp_pkg::STS_RANGE;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_INIT;
                end
            end

            // Link the new edge in front of the tail's list.
            S_ADD:
            begin
                edge_we         = 1'b1;
                head_we         = 1'b1;
                head_wa         = req_a_reg;
                head_wd         = edge_total_reg;
                edge_total_next = edge_total_reg + EW'(1);
                fin             = 1'b1;
                state_next      = S_IDLE;
            end

            S_RDD:
            begin
                fin        = 1'b1;
                fin_dist   = dist_rd;
                fin_reach  = (dist_rd != dsp_pkg::UNREACHED);
                state_next = S_IDLE;
            end

            S_INIT:
            begin
                dist_we        = 1'b1;
                dist_wa        = VW'(source_vertex_reg);
                dist_wd        = '0;
                heap_we        = 1'b1;
                heap_wa        = '0;
                heap_wd        = {{DB{1'b0}}, VW'(source_vertex_reg)};
                heap_fill_next = HW'(1);
                state_next     = S_POP;
            end

            S_POP:
            begin
                heap_ra = '0;
                if (heap_fill_reg == '0)
                begin
                    idx_next   = '0;
                    cnt_next   = '0;
                    state_next = S_CNT;
                end
                else
                begin
                    heap_fill_next = heap_fill_reg - HW'(1);
                    state_next     = S_POPL;
                end
            end

            S_POPL:
            begin
                top_next   = heap_rd;
                heap_ra    = HAW'(heap_fill_reg);
                state_next = (heap_fill_reg == '0) ? S_CHK : S_SDI;
            end

            S_SDI:
            begin
                key_next   = heap_rd;
                hi_next    = '0;
                state_next = S_SDC;
            end

            // Sift the former last entry down from the root.
            S_SDC:
            begin
                heap_ra = HAW'(c_w);
                if (c_w >= fill_c)
                begin
                    heap_we    = 1'b1;
                    state_next = S_CHK;
                end
                else
                    state_next = S_SDC1;
            end

            S_SDC1:
            begin
                best_next = heap_rd;
                bc_next   = HAW'(c_w);
                heap_ra   = HAW'(c1_w);
                state_next = (c1_w < fill_c) ? S_SDCMP : S_SDM;
            end

            S_SDCMP:
            begin
                if (heap_rd < best_reg)
                begin
                    best_next = heap_rd;
                    bc_next   = HAW'(c1_w);
                end
                state_next = S_SDM;
            end

            S_SDM:
            begin
                heap_we = 1'b1;
                if (key_reg <= best_reg)
                    state_next = S_CHK;
                else
                begin
                    heap_wd    = best_reg;
                    hi_next    = bc_reg;
                    state_next = S_SDC;
                end
            end

            S_CHK:
            begin
                dist_ra = top_v;
                state_next = (CW'(top_v) >= n_cw) ? S_POP : S_CHK2;
            end

            // Drop stale entries: the vertex already settled at a shorter distance.
            S_CHK2:
            begin
                head_ra = top_v;
                state_next = (dist_rd < top_d) ? S_POP : S_HEAD;
            end

            S_HEAD:
            begin
                link_next  = head_rd;
                state_next = S_ELOOP;
            end

            S_ELOOP:
            begin
                state_next = (link_reg == EW'(MAX_EDGES)) ? S_POP : S_EDGE;
            end

            S_EDGE:
            begin
                link_next = nxt_rd;
                nd_next   = sat_w;
                v_next    = tgt_rd;
                dist_ra   = tgt_rd;
                state_next = (CW'(tgt_rd) >= n_cw) ? S_ELOOP : S_RELAX;
            end

            S_RELAX:
            begin
                state_next = S_ELOOP;
                if (nd_reg < dist_rd)
                begin
                    dist_we = 1'b1;
                    dist_wa = v_reg;
                    dist_wd = nd_reg;
                    if (heap_fill_reg < HW'(HCAP))
                    begin
                        hi_next        = HAW'(heap_fill_reg);
                        heap_fill_next = heap_fill_reg + HW'(1);
                        key_next       = {nd_reg, v_reg};
                        state_next     = S_PUC;
                    end
                end
            end

            // Sift the new entry up toward the root.
            S_PUC:
            begin
                heap_ra = p_w;
                if (hi_reg == '0)
                begin
                    heap_we    = 1'b1;
                    state_next = S_ELOOP;
                end
                else
                    state_next = S_PUM;
            end

            S_PUM:
            begin
                heap_we = 1'b1;
                if (heap_rd <= key_reg)
                    state_next = S_ELOOP;
                else
                begin
                    heap_wd    = heap_rd;
                    hi_next    = p_w;
                    state_next = S_PUC;
                end
            end

            S_CNT:
            begin
                state_next = S_CNTA;
            end

            S_CNTA:
            begin
                cnt_next = cnt_reg + NW'(dist_rd != dsp_pkg::UNREACHED);
                if (CW'(idx_reg) == n_cw - CW'(1))
                begin
                    fin        = 1'b1;
                    fin_count  = cnt_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + VW'(1);
                    state_next = S_CNT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the response until taken; a new one lands only when the slot is free.
    assign res_valid_next = fin ? 1'b1 : (rsp.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            boot_reg        <= 1'b1;
            sweep_graph_reg <= 1'b1;
            run_bad_reg     <= 1'b0;
            idx_reg         <= '0;
            edge_total_reg  <= '0;
            heap_fill_reg   <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            boot_reg        <= boot_next;
            sweep_graph_reg <= sweep_graph_next;
            run_bad_reg     <= run_bad_next;
            idx_reg         <= idx_next;
            edge_total_reg  <= edge_total_next;
            heap_fill_reg   <= heap_fill_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_a_reg <= req_a_next;
        req_b_reg <= req_b_next;
        w_reg     <= w_next;
        hi_reg    <= hi_next;
        bc_reg    <= bc_next;
        key_reg   <= key_next;
        best_reg  <= best_next;
        top_reg   <= top_next;
        link_reg  <= link_next;
        nd_reg    <= nd_next;
        v_reg     <= v_next;
        cnt_reg   <= cnt_next;
        if (fin)
        begin
            res_status_reg <= fin_status;
            res_dist_reg   <= fin_dist;
            res_reach_reg  <= fin_reach;
            res_count_reg  <= (dsp_pkg::COUNT_W)'(fin_count);
        end
    end

    assign rsp.valid         = res_valid_reg;
    assign rsp.status        = res_status_reg;
    assign rsp.distance      = res_dist_reg;
    assign rsp.reachable     = res_reach_reg;
    assign rsp.reached_count = res_count_reg;

    // ---------------- assertions ----------------
    `DSP_ASSERT_NOW(a_heap_cap, clk, rst_n, 1'b1, heap_fill_reg <= HW'(HCAP))
    `DSP_ASSERT_NOW(a_edge_cap, clk, rst_n, 1'b1, edge_total_reg <= EW'(MAX_EDGES))
    `DSP_ASSERT_NOW(a_no_boot_accept, clk, rst_n, boot_reg, !req.ready)
    `DSP_ASSERT_NEXT(a_fin_shows, clk, rst_n, fin, rsp.valid)

endmodule
